// ----- rtl/core/hkst_pkg.sv -----
`default_nettype none
package hkst_pkg;

    // table geometry
    localparam int unsigned HKST_SLOTS = 256;

    // murmur2-style mixing constants
    localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam logic [31:0] HASH_SEED   = 32'd137173456;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [63:0] SEED_PROD   = 64'(HASH_SEED) * 64'(MIX_MUL);
    localparam logic [31:0] SEED_MIX    = SEED_PROD[31:0];

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_RINSE  = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_CREATED = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_RINSED  = 3'd4,
        ST_LIST    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_RD,
        S_CMP,
        S_LIST
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/hkst_ram.sv -----
`default_nettype none
module hkst_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = hkst_pkg::HKST_SLOTS,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    import hkst_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/hkst_hash.sv -----
`default_nettype none
module hkst_hash #(
    parameter int unsigned TABLE_SLOTS = hkst_pkg::HKST_SLOTS,
    localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [31:0]       i_w0,
    input  wire logic [31:0]       i_w1,
    input  wire logic [31:0]       i_w2,
    output logic                   o_done,
    output logic      [SLOT_W-1:0] o_index
);
    import hkst_pkg::*;

    localparam logic [31:0] MODULUS = 32'(TABLE_SLOTS);
    // floor of 2^32 over the table size: quotient estimate is exact or one low
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_SLOTS);
    localparam logic [2:0] PH_MUL0  = 3'd0;
    localparam logic [2:0] PH_MUL1  = 3'd1;
    localparam logic [2:0] PH_MUL2  = 3'd2;
    localparam logic [2:0] PH_FIN   = 3'd3;
    localparam logic [2:0] PH_QUO   = 3'd4;
    localparam logic [2:0] PH_BACK  = 3'd5;
    localparam logic [2:0] PH_FIX   = 3'd6;

    logic              r_busy, n_busy;
    logic [2:0]        r_phase, n_phase;
    logic [31:0]       r_val, n_val;
    logic [31:0]       r_quo, n_quo;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic              r_done, n_done;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [31:0]       seed_x;
    logic [63:0]       prod;

    // operands for the shared multiplier in each phase
    always_comb begin
        seed_x = SEED_MIX ^ r_val;
        mul_a  = r_val;
        mul_b  = MIX_MUL;
        case (r_phase)
            PH_MUL0: mul_a = r_val;
            PH_MUL1: mul_a = r_val ^ (r_val >> MIX_SHIFT);
            PH_MUL2: mul_a = seed_x ^ (seed_x >> FIN_SHIFT_A);
            PH_QUO:  mul_b = RECIP;
            PH_BACK: begin
                mul_a = r_quo;
                mul_b = MODULUS;
            end
            default: mul_a = r_val;
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    // phase sequencer: three mixing products, final fold, then reduction
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_val   = r_val;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_done  = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy  = 1'b1;
                n_phase = PH_MUL0;
                n_val   = i_w0 ^ i_w1 ^ i_w2;
            end
        end else begin
            n_phase = r_phase + 3'd1;
            case (r_phase)
                PH_MUL0, PH_MUL1, PH_MUL2: begin
                    n_val = prod[31:0];
                end
                PH_FIN: begin
                    n_val = r_val ^ (r_val >> FIN_SHIFT_B);
                end
                PH_QUO: begin
                    n_quo = prod[63:32];
                end
                PH_BACK: begin
                    // remainder before correction, below twice the table size
                    n_val = r_val - prod[31:0];
                end
                PH_FIX: begin
                    n_rem  = (r_val >= MODULUS) ? SLOT_W'(r_val - MODULUS)
                                                : SLOT_W'(r_val);
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_MUL0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
        end
        r_val <= n_val;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done  = r_done;
    assign o_index = r_rem;

endmodule
`default_nettype wire

// ----- rtl/core/hashed_key_slot_table.sv -----
// channel   direction  handshake                  payload
// command   in         start high, busy low       i_mode, i_key_word0..2, i_list_pos
// result    out        o_valid, one cycle         o_status, o_slot, o_used_total
//
// find and find-or-create: hashing and slot reduction (one shared multiplier:
// three mixing products, a final fold, a reciprocal quotient and its
// back-multiply, then a correcting subtract), then a read and a compare per
// probed slot through the key memory read port, then the result register.
// read-list: through the registered list memory read; rinse: in the next cycle.
// reset empties the table at once through per-slot valid flip-flops.
// results cannot be stalled; busy holds off further commands.
`default_nettype none
module hashed_key_slot_table #(
    parameter int unsigned TABLE_SLOTS = hkst_pkg::HKST_SLOTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_key_word0,
    input  wire logic [31:0] i_key_word1,
    input  wire logic [31:0] i_key_word2,
    input  wire logic [7:0]  i_list_pos,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [7:0]       o_slot,
    output logic [8:0]       o_used_total
);
    import hkst_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W  = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(TABLE_SLOTS);

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [31:0]         r_w0, r_w1, r_w2, n_w0, n_w1, n_w2;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]    r_probe, n_probe;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;
    logic                r_vld_rd, n_vld_rd;
    logic                r_o_valid, n_o_valid;
    t_status             r_o_status, n_o_status;
    logic [SLOT_W-1:0]   r_o_slot, n_o_slot;

    logic                accept;
    logic                hash_start;
    logic                hash_done;
    logic [SLOT_W-1:0]   hash_index;
    logic                key_we;
    logic [95:0]         key_rd;
    logic                list_we;
    logic [SLOT_W-1:0]   list_raddr;
    logic [SLOT_W-1:0]   list_rd;
    logic                key_match;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign hash_start = accept && (t_mode'(i_mode) == MODE_FIND ||
                                   t_mode'(i_mode) == MODE_CREATE);
    assign list_raddr = SLOT_W'(i_list_pos);
    assign key_match  = (key_rd == {r_w2, r_w1, r_w0});

    // hash and start slot
    hkst_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_w0    (i_key_word0),
        .i_w1    (i_key_word1),
        .i_w2    (i_key_word2),
        .o_done  (hash_done),
        .o_index (hash_index)
    );

    // key store, all three words side by side
    hkst_ram #(.WIDTH(96), .DEPTH(TABLE_SLOTS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_idx),
        .i_wdata ({r_w2, r_w1, r_w0}),
        .i_raddr (r_idx),
        .o_rdata (key_rd)
    );

    // used list in order of claiming
    hkst_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (r_count[SLOT_W-1:0]),
        .i_wdata (r_idx),
        .i_raddr (list_raddr),
        .o_rdata (list_rd)
    );

    // command sequencer and probe walk
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_w0       = r_w0;
        n_w1       = r_w1;
        n_w2       = r_w2;
        n_idx      = r_idx;
        n_probe    = r_probe;
        n_count    = r_count;
        n_valid    = r_valid;
        n_vld_rd   = r_vld_rd;
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        key_we     = 1'b0;
        list_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = t_mode'(i_mode);
                    n_w0   = i_key_word0;
                    n_w1   = i_key_word1;
                    n_w2   = i_key_word2;
                    case (t_mode'(i_mode))
                        MODE_FIND, MODE_CREATE: begin
                            n_state = S_HASH;
                        end
                        MODE_RINSE: begin
                            n_valid    = '0;
                            n_count    = '0;
                            n_o_valid  = 1'b1;
                            n_o_status = ST_RINSED;
                            n_o_slot   = '0;
                        end
                        default: begin
                            if (32'(i_list_pos) < 32'(r_count)) begin
                                n_state = S_LIST;
                            end else begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_ABSENT;
                                n_o_slot   = '0;
                            end
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_idx   = hash_index;
                    n_probe = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_vld_rd = r_valid[r_idx];
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (!r_vld_rd) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    n_o_slot  = '0;
                    if (r_count >= SLOTS_C) begin
                        n_o_status = ST_FULL;
                    end else if (r_mode == MODE_FIND) begin
                        n_o_status = ST_ABSENT;
                    end else begin
                        key_we         = 1'b1;
                        list_we        = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_count        = r_count + 1'b1;
                        n_o_status     = ST_CREATED;
                        n_o_slot       = r_idx;
                    end
                end else if (key_match) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_FOUND;
                    n_o_slot   = r_idx;
                    n_state    = S_IDLE;
                end else if (r_probe == SLOTS_C - 1'b1) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_FULL;
                    n_o_slot   = '0;
                    n_state    = S_IDLE;
                end else begin
                    n_idx   = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
                    n_probe = r_probe + 1'b1;
                    n_state = S_RD;
                end
            end
            S_LIST: begin
                n_o_valid  = 1'b1;
                n_o_status = ST_LIST;
                n_o_slot   = list_rd;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
        end
        r_mode     <= n_mode;
        r_w0       <= n_w0;
        r_w1       <= n_w1;
        r_w2       <= n_w2;
        r_idx      <= n_idx;
        r_probe    <= n_probe;
        r_vld_rd   <= n_vld_rd;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot       = 8'(r_o_slot);
    assign o_used_total = 9'(r_count);

    // count never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("used count beyond table size");

    // rinse answers next cycle with an empty table
    a_rinse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_mode'(i_mode) == MODE_RINSE) |=>
        (o_valid && o_status == ST_RINSED && r_count == '0))
        else $error("rinse result missing");

    // a created slot bumps the count by one
    a_create_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_CREATED) |-> (r_count == $past(r_count) + 1'b1))
        else $error("create did not advance count");

    // a found or created result only leaves the compare state
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FOUND || o_status == ST_CREATED)) |->
        ($past(r_state) == S_CMP))
        else $error("probe result without compare");

endmodule
`default_nettype wire

// ----- tb/sv/hashed_key_slot_table_checker.sv -----
`timescale 1ns / 1ps
module hashed_key_slot_table_checker
    import hkst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_key_word0,
    input  wire logic [31:0] i_key_word1,
    input  wire logic [31:0] i_key_word2,
    input  wire logic [7:0]  i_list_pos,
    input  wire logic        o_valid,
    input  wire logic [2:0]  o_status,
    input  wire logic [7:0]  o_slot,
    input  wire logic [8:0]  o_used_total,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        t_status    status;
        logic [7:0] slot;
        logic [8:0] used_total;
    } t_outcome;

    // shadow copy of the table
    logic [31:0] shadow_w0 [HKST_SLOTS];
    logic [31:0] shadow_w1 [HKST_SLOTS];
    logic [31:0] shadow_w2 [HKST_SLOTS];
    logic        shadow_valid [HKST_SLOTS];
    logic [7:0]  shadow_list [HKST_SLOTS];
    int unsigned shadow_count;
    t_outcome    outcome_q [$];

    assign pending = outcome_q.size();

    function automatic logic [31:0] murmur_mix(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        logic [31:0] k;
        logic [31:0] h;
        k = a ^ b ^ c;
        k = k * MIX_MUL;
        k ^= k >> MIX_SHIFT;
        k = k * MIX_MUL;
        h = HASH_SEED * MIX_MUL;
        h ^= k;
        h ^= h >> FIN_SHIFT_A;
        h = h * MIX_MUL;
        h ^= h >> FIN_SHIFT_B;
        return h;
    endfunction

    function automatic t_outcome table_op(t_mode mode, logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [7:0] pos);
        t_outcome res;
        int unsigned idx;
        int          hit;
        int unsigned at;
        res = '{ST_ABSENT, 8'd0, 9'd0};
        hit = -1;
        at = 0;
        if (mode == MODE_FIND || mode == MODE_CREATE) begin
            idx = murmur_mix(a, b, c) % HKST_SLOTS;
            for (int n = 0; n < HKST_SLOTS && hit < 0; n++) begin
                if (!shadow_valid[idx]) begin
                    hit = 0;
                    at = idx;
                end else if (shadow_w0[idx] == a && shadow_w1[idx] == b
                             && shadow_w2[idx] == c) begin
                    hit = 1;
                    at = idx;
                end
                idx = (idx + 1) % HKST_SLOTS;
            end
            if (hit == 1) begin
                res.status = ST_FOUND;
                res.slot = at[7:0];
            end else if (hit < 0 || shadow_count >= HKST_SLOTS) begin
                res.status = ST_FULL;
            end else if (mode == MODE_CREATE) begin
                shadow_valid[at] = 1'b1;
                shadow_w0[at] = a;
                shadow_w1[at] = b;
                shadow_w2[at] = c;
                shadow_list[shadow_count] = at[7:0];
                shadow_count++;
                res.status = ST_CREATED;
                res.slot = at[7:0];
            end
        end else if (mode == MODE_RINSE) begin
            for (int n = 0; n < HKST_SLOTS; n++) shadow_valid[n] = 1'b0;
            shadow_count = 0;
            res.status = ST_RINSED;
        end else if (pos < shadow_count) begin
            res.status = ST_LIST;
            res.slot = shadow_list[pos];
        end
        res.used_total = shadow_count[8:0];
        return res;
    endfunction

    // predict on accepted items, compare on strobed results
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int n = 0; n < HKST_SLOTS; n++) shadow_valid[n] = 1'b0;
            shadow_count = 0;
            outcome_q.delete();
            fail_count = 0;
        end else begin
            if (o_valid) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_slot !== want.slot) begin
                        $error("slot expected %0d actual %0d", want.slot, o_slot);
                        fail_count++;
                    end
                    if (o_used_total !== want.used_total) begin
                        $error("used_total expected %0d actual %0d",
                               want.used_total, o_used_total);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(table_op(t_mode'(i_mode), i_key_word0, i_key_word1,
                                             i_key_word2, i_list_pos));
        end
    end

endmodule

// ----- tb/sv/hashed_key_slot_table_tb.sv -----
`timescale 1ns / 1ps
module hashed_key_slot_table_tb;
    import hkst_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_mode = MODE_FIND;
    logic [31:0] i_key_word0 = '0;
    logic [31:0] i_key_word1 = '0;
    logic [31:0] i_key_word2 = '0;
    logic [7:0]  i_list_pos = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_slot;
    logic [8:0]  o_used_total;
    int          fail_count;
    int          pending;

    // recently used keys, so finds and repeats hit
    logic [95:0] key_pool [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    hashed_key_slot_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_key_word0(i_key_word0), .i_key_word1(i_key_word1),
        .i_key_word2(i_key_word2), .i_list_pos(i_list_pos), .o_valid(o_valid),
        .o_status(o_status), .o_slot(o_slot), .o_used_total(o_used_total)
    );

    hashed_key_slot_table_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_key_word0(i_key_word0), .i_key_word1(i_key_word1),
        .i_key_word2(i_key_word2), .i_list_pos(i_list_pos), .o_valid(o_valid),
        .o_status(o_status), .o_slot(o_slot), .o_used_total(o_used_total),
        .fail_count(fail_count), .pending(pending)
    );

    // present one item and hold it until accepted; optional idle burst first
    task automatic send_item(t_mode mode, logic [95:0] key, logic [7:0] pos, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_mode      <= mode;
        i_key_word0 <= key[31:0];
        i_key_word1 <= key[63:32];
        i_key_word2 <= key[95:64];
        i_list_pos  <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [95:0] fresh_key();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // random item, mostly creates and finds over pooled keys
    task automatic random_item(bit gaps);
        int unsigned pick;
        logic [95:0] key;
        pick = $urandom_range(0, 99);
        key = fresh_key();
        if (key_pool.size() > 0 && $urandom_range(0, 1) == 1)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if ($urandom_range(0, 7) == 0)
            key[63:32] = key[31:0] ^ key[95:64]; // xor-fold gives zero
        if (pick < 50) begin
            send_item(MODE_CREATE, key, 8'($urandom()), gaps);
            key_pool.push_back(key);
            if (key_pool.size() > 64) void'(key_pool.pop_front());
        end else if (pick < 80) begin
            send_item(MODE_FIND, key, 8'($urandom()), gaps);
        end else if (pick < 98) begin
            send_item(MODE_LIST, fresh_key(), 8'($urandom()), gaps);
        end else begin
            send_item(MODE_RINSE, fresh_key(), 8'($urandom()), gaps);
        end
    endtask

    initial begin
        logic [95:0] base;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table cases, extremes, collisions
        send_item(MODE_FIND, '0, 8'd0, 0);
        send_item(MODE_LIST, '1, 8'd0, 0);
        send_item(MODE_CREATE, '0, 8'hff, 0);
        send_item(MODE_CREATE, '1, 8'd0, 0);
        send_item(MODE_CREATE, '1, 8'd0, 0);
        send_item(MODE_FIND, '1, 8'd0, 0);
        base = fresh_key();
        // same xor fold, different keys: same probe start
        send_item(MODE_CREATE, base, 8'd0, 0);
        send_item(MODE_CREATE, {base[95:64] ^ 32'h1, base[63:32] ^ 32'h1, base[31:0]}, 8'd0, 0);
        send_item(MODE_FIND, {base[95:64] ^ 32'h1, base[63:32] ^ 32'h1, base[31:0]}, 8'd0, 0);
        send_item(MODE_FIND, {base[95:64] ^ 32'h2, base[63:32] ^ 32'h2, base[31:0]}, 8'd0, 0);
        send_item(MODE_LIST, '0, 8'd0, 0);
        send_item(MODE_LIST, '0, 8'd3, 0);
        send_item(MODE_LIST, '0, 8'd4, 0);
        send_item(MODE_LIST, '0, 8'hff, 0);
        send_item(MODE_RINSE, '1, 8'hff, 0);
        send_item(MODE_FIND, '1, 8'd0, 0);
        send_item(MODE_LIST, '0, 8'd0, 0);

        // fill the table to full, then probe full behaviour
        for (int n = 0; n < 256; n++) send_item(MODE_CREATE, fresh_key(), 8'd0, n % 40 == 0);
        send_item(MODE_CREATE, fresh_key(), 8'd0, 0);
        send_item(MODE_FIND, fresh_key(), 8'd0, 0);
        send_item(MODE_LIST, '0, 8'hff, 0);
        send_item(MODE_RINSE, '0, 8'd0, 0);

        // random with idle bursts
        for (int n = 0; n < 1100; n++) random_item(1);

        // hold off until every result is in
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat ($urandom_range(1, 17)) @(posedge i_clk);

        // last part without idling
        for (int n = 0; n < 200; n++) random_item(0);
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0)
            $display("hashed_key_slot_table_tb OK");
        else
            $display("hashed_key_slot_table_tb NOT OK");
        $finish;
    end

    // run limit
    initial begin
        #100ms;
        $display("hashed_key_slot_table_tb NOT OK");
        $finish;
    end

endmodule

// ----- hashed_key_slot_table.f -----
rtl/core/hkst_pkg.sv
rtl/core/hkst_ram.sv
rtl/core/hkst_hash.sv
rtl/core/hashed_key_slot_table.sv
tb/sv/hashed_key_slot_table_checker.sv
tb/sv/hashed_key_slot_table_tb.sv
